[hw/rtl/zrs_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and controller/datapath interface types for the Zipf rank sampler.
// Depends on nothing; every other file but zrs_ram refers to it by scoped names.

package zrs_pkg;

  localparam int MAX_RANKS = 1024;
  localparam int IDX_W     = 11;
  localparam int VAL_W     = 31;
  localparam int ADDR_W    = $clog2(MAX_RANKS);

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic start;     // begin a search on the captured sample
    logic load;      // write one table entry
    logic advance;   // narrow the search interval
    logic out_load;  // capture the result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;     // search interval is empty
    logic hit;       // current midpoint matches
  } sts_t;

endpackage

[hw/rtl/zrs_ram.sv]
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports, registered read data.
// Self-contained; no package dependency.

module zrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hw/rtl/zrs_dpath.sv]
`timescale 1ns / 1ps
// Datapath: threshold table, search bounds, compares and the output register.
// Depends on zrs_pkg and zrs_ram.

module zrs_dpath (
  input  logic                      clk,
  input  logic                      rst,
  input  zrs_pkg::cmd_t             cmd,
  output zrs_pkg::sts_t             sts,
  input  logic [zrs_pkg::IDX_W-1:0] entry_index,
  input  logic [zrs_pkg::VAL_W-1:0] entry_value,
  input  logic [zrs_pkg::VAL_W-1:0] uniform_value,
  input  logic                      cfg_we,
  input  logic [zrs_pkg::IDX_W-1:0] cfg_data,
  output logic [zrs_pkg::IDX_W-1:0] rank,
  output logic                      found
);

  localparam logic [zrs_pkg::IDX_W-1:0] ONE     = zrs_pkg::IDX_W'(1);
  localparam logic [zrs_pkg::IDX_W-1:0] TWO     = zrs_pkg::IDX_W'(2);
  localparam logic [zrs_pkg::IDX_W-1:0] MAX_IDX = zrs_pkg::IDX_W'(zrs_pkg::MAX_RANKS);

  logic [zrs_pkg::IDX_W-1:0]  rank_count;
  logic [zrs_pkg::IDX_W-1:0]  low, low_next;
  logic [zrs_pkg::IDX_W-1:0]  high, high_next;
  logic [zrs_pkg::IDX_W-1:0]  mid, mid_next;
  logic [zrs_pkg::IDX_W:0]    mid_sum;
  logic [zrs_pkg::IDX_W-1:0]  mid_m1, mid_m2, load_m1, count_sat;
  logic [zrs_pkg::VAL_W-1:0]  uval;
  logic [zrs_pkg::VAL_W-1:0]  thr_hi, thr_lo, rd_a, rd_b;
  logic                       lt, le_lo, load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_count <= MAX_IDX;
    end else if (cfg_we) begin
      rank_count <= cfg_data;
    end
  end

  assign count_sat = (rank_count > MAX_IDX) ? MAX_IDX : rank_count;

  // Threshold of rank mid sits at mid-1; rank mid-1 at mid-2, zero for rank 0.
  assign thr_hi = rd_a;
  assign thr_lo = (mid == ONE) ? '0 : rd_b;

  assign lt    = thr_hi < uval;
  assign le_lo = uval <= thr_lo;
  assign sts.empty = low > high;
  assign sts.hit   = !sts.empty && !lt && !le_lo;

  always_comb begin
    low_next  = low;
    high_next = high;
    if (cmd.start) begin
      low_next  = ONE;
      high_next = count_sat;
    end else if (cmd.advance) begin
      if (lt) begin
        low_next = mid + ONE;
      end else begin
        high_next = mid - ONE;
      end
    end
    mid_sum  = {1'b0, low_next} + {1'b0, high_next};
    mid_next = mid_sum[zrs_pkg::IDX_W:1];
  end

  always_ff @(posedge clk) begin
    low  <= low_next;
    high <= high_next;
    mid  <= mid_next;
    if (cmd.start) begin
      uval <= uniform_value;
    end
    if (cmd.out_load) begin
      rank  <= sts.hit ? mid : '0;
      found <= sts.hit;
    end
  end

  // Address the table with the next midpoint so data lines up with mid.
  assign mid_m1  = mid_next - ONE;
  assign mid_m2  = mid_next - TWO;
  assign load_m1 = entry_index - ONE;
  assign load_ok = (entry_index >= ONE) && (entry_index <= MAX_IDX);

  zrs_ram #(
    .WIDTH (zrs_pkg::VAL_W),
    .DEPTH (zrs_pkg::MAX_RANKS)
  ) u_table (
    .clk     (clk),
    .we      (cmd.load && load_ok),
    .waddr   (load_m1[zrs_pkg::ADDR_W-1:0]),
    .wdata   (entry_value),
    .raddr_a (mid_m1[zrs_pkg::ADDR_W-1:0]),
    .raddr_b (mid_m2[zrs_pkg::ADDR_W-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

endmodule

[hw/rtl/zrs_ctrl.sv]
`timescale 1ns / 1ps
// Controller: input/output handshakes and the search sequencer.
// Depends on zrs_pkg; drives the datapath through cmd_t and reads sts_t.

module zrs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          req_type,
  output logic          out_valid,
  input  logic          out_stall,
  output zrs_pkg::cmd_t cmd,
  input  zrs_pkg::sts_t sts
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic state, state_next;
  logic out_valid_next;
  logic in_xfer, out_free, done;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign done     = sts.empty || sts.hit;

  always_comb begin
    state_next   = state;
    cmd.start    = 1'b0;
    cmd.load     = 1'b0;
    cmd.advance  = 1'b0;
    cmd.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (req_type == zrs_pkg::REQ_SAMPLE) begin
            cmd.start  = 1'b1;
            state_next = ST_SEARCH;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        if (done) begin
          // hold the bounds until the output register frees up
          if (out_free) begin
            cmd.out_load = 1'b1;
            state_next   = ST_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_search_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH && !done) |=> (state == ST_SEARCH))
    else $error("search left before finishing");

  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && req_type == zrs_pkg::REQ_SAMPLE) |=> (state == ST_SEARCH))
    else $error("sample transfer did not start a search");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result captured but not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("pending result overwritten");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!cmd.advance && !cmd.out_load))
    else $error("search commands while idle");

endmodule

[hw/rtl/zipf_rank_sampler.sv]
`timescale 1ns / 1ps
// Zipf rank sampler: maps a uniform value to a rank by inverse-CDF binary search.
// Depends on zrs_pkg, zrs_ctrl and zrs_dpath.
//
// Input channel (in_valid/in_stall): req_type 0 loads entry_value as the
// cumulative threshold of rank entry_index (1..1024, others dropped) and gives
// no result; req_type 1 searches ranks 1..rank_count for the rank r with
// threshold[r-1] < uniform_value <= threshold[r] (threshold of rank 0 is zero).
// Output channel (out_valid/out_stall): one transfer of rank/found per sample;
// rank 0 with found 0 when no interval matches. Every threshold the search
// touches must have been loaded first.
// Config channel (cfg_valid/cfg_ready): writes rank_count; always ready. Write
// it only while the block is idle; values above 1024 act as 1024.
// Sequence: a load is written as it is accepted. A sample is accepted, then the
// search makes one table compare per step against the registered-read memory,
// with one more step when the interval runs empty; the result then goes to the
// output register. in_stall is high while a search runs.
// When the receiver stalls, the result holds in the output register; the next
// item is still accepted, and a finished search waits until that result moves.
// Reset clears the control state and sets rank_count to 1024; the table is not
// cleared.

module zipf_rank_sampler (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      req_type,
  input  logic [zrs_pkg::IDX_W-1:0] entry_index,
  input  logic [zrs_pkg::VAL_W-1:0] entry_value,
  input  logic [zrs_pkg::VAL_W-1:0] uniform_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [zrs_pkg::IDX_W-1:0] rank,
  output logic                      found,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [zrs_pkg::IDX_W-1:0] cfg_data
);

  zrs_pkg::cmd_t cmd;
  zrs_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  zrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  zrs_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .entry_index   (entry_index),
    .entry_value   (entry_value),
    .uniform_value (uniform_value),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .rank          (rank),
    .found         (found)
  );

endmodule

[verif/zipf_rank_sampler_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for zipf_rank_sampler: loads threshold tables, draws samples
// and compares every rank/found transfer with an in-bench binary-search predictor.
// Depends on zrs_pkg and the zipf_rank_sampler top level.

typedef struct packed {
  logic [zrs_pkg::IDX_W-1:0] rank;
  logic                      found;
} rank_result_t;

class rank_scoreboard;
  logic [zrs_pkg::VAL_W-1:0] cdf [zrs_pkg::MAX_RANKS];
  bit                        loaded [zrs_pkg::MAX_RANKS];
  logic [zrs_pkg::IDX_W-1:0] rank_count;
  rank_result_t              pending_ranks [$];
  int                        errors;
  int                        loads;
  int                        samples;
  int                        hits;
  int                        misses;

  function new();
    foreach (cdf[i]) begin
      cdf[i]    = '0;
      loaded[i] = 1'b0;
    end
    rank_count = zrs_pkg::IDX_W'(zrs_pkg::MAX_RANKS);
    errors     = 0;
    loads      = 0;
    samples    = 0;
    hits       = 0;
    misses     = 0;
  endfunction

  // Rank 0 and anything past the table read as zero.
  function logic [zrs_pkg::VAL_W-1:0] threshold(int r);
    if (r <= 0 || r > zrs_pkg::MAX_RANKS) return '0;
    return cdf[r-1];
  endfunction

  function rank_result_t lookup_rank(logic [zrs_pkg::VAL_W-1:0] u);
    int           lo;
    int           hi;
    int           mid;
    rank_result_t res;
    res = '0;
    lo  = 1;
    hi  = int'(rank_count);
    if (hi > zrs_pkg::MAX_RANKS) hi = zrs_pkg::MAX_RANKS;
    while (lo <= hi && !res.found) begin
      mid = (lo + hi) / 2;
      if (threshold(mid) < u) begin
        lo = mid + 1;
      end else if (u <= threshold(mid - 1)) begin
        hi = mid - 1;
      end else begin
        res.rank  = mid[zrs_pkg::IDX_W-1:0];
        res.found = 1'b1;
      end
    end
    return res;
  endfunction

  function void note_item(logic req, logic [zrs_pkg::IDX_W-1:0] idx,
                          logic [zrs_pkg::VAL_W-1:0] val, logic [zrs_pkg::VAL_W-1:0] u);
    if (req == zrs_pkg::REQ_LOAD) begin
      loads++;
      if (idx >= 1 && idx <= zrs_pkg::MAX_RANKS) begin
        cdf[idx-1]    = val;
        loaded[idx-1] = 1'b1;
      end
    end else begin
      samples++;
      pending_ranks.push_back(lookup_rank(u));
    end
  endfunction

  function void check_result(logic [zrs_pkg::IDX_W-1:0] rank, logic found);
    rank_result_t exp_res;
    if (pending_ranks.size() == 0) begin
      $error("unexpected result transfer: rank %0d found %0d", rank, found);
      errors++;
      return;
    end
    exp_res = pending_ranks.pop_front();
    if (rank !== exp_res.rank) begin
      $error("rank mismatch: expected %0d, actual %0d", exp_res.rank, rank);
      errors++;
    end
    if (found !== exp_res.found) begin
      $error("found mismatch: expected %0d, actual %0d", exp_res.found, found);
      errors++;
    end
    if (exp_res.found) hits++;
    else misses++;
  endfunction
endclass

module zipf_rank_sampler_tb;

  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 20;
  localparam logic [zrs_pkg::VAL_W-1:0] VAL_MAX = '1;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic                      req_type;
  logic [zrs_pkg::IDX_W-1:0] entry_index;
  logic [zrs_pkg::VAL_W-1:0] entry_value;
  logic [zrs_pkg::VAL_W-1:0] uniform_value;
  logic                      out_valid;
  logic                      out_stall;
  logic [zrs_pkg::IDX_W-1:0] rank;
  logic                      found;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [zrs_pkg::IDX_W-1:0] cfg_data;

  rank_scoreboard sb;
  bit             idling;
  bit             hold_off_req;
  bit             hold_done;
  int             cycle_count;
  int             configs;

  zipf_rank_sampler dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .uniform_value(uniform_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rank         (rank),
    .found        (found),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off to back up the block.
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(rank, found);
  end

  // Entered after a rising edge; returns at the edge where the transfer happens.
  task automatic send_item(input logic req, input logic [zrs_pkg::IDX_W-1:0] idx,
                           input logic [zrs_pkg::VAL_W-1:0] val,
                           input logic [zrs_pkg::VAL_W-1:0] u);
    @(negedge clk);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid      = 1'b1;
    req_type      = req;
    entry_index   = idx;
    entry_value   = val;
    uniform_value = u;
    do @(posedge clk); while (in_stall);
    sb.note_item(req, idx, val, u);
  endtask

  task automatic halt_items;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Drain all results, then let any trailing load finish before touching config.
  task automatic settle;
    while (sb.pending_ranks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_rank_count(input logic [zrs_pkg::IDX_W-1:0] v);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sb.rank_count = v;
    configs++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Load a monotone table over ranks 1..n; keep a large one if it is fully loaded.
  task automatic build_table(input int n);
    longint acc;
    longint step;
    bit     rebuild;
    rebuild = (n <= 400);
    for (int k = 1; k <= n; k++) if (!sb.loaded[k-1]) rebuild = 1'b1;
    if (rebuild && n > 0) begin
      step = 64'h7FFF_FFFF / n;
      acc  = 0;
      for (int k = 1; k <= n; k++) begin
        // occasional zero step gives an empty interval
        if ($urandom_range(0, 15) != 0) acc += $urandom_range(1, int'(step));
        send_item(zrs_pkg::REQ_LOAD, k[zrs_pkg::IDX_W-1:0], acc[zrs_pkg::VAL_W-1:0],
                  zrs_pkg::VAL_W'($urandom));
      end
    end
  endtask

  task automatic random_item(input int n);
    int                        pick;
    int                        k;
    logic [zrs_pkg::VAL_W-1:0] u;
    logic [zrs_pkg::VAL_W-1:0] lo;
    logic [zrs_pkg::VAL_W-1:0] hi;
    logic [zrs_pkg::VAL_W-1:0] last;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      send_item(zrs_pkg::REQ_LOAD, '0, zrs_pkg::VAL_W'($urandom),
                zrs_pkg::VAL_W'($urandom));
    end else if (pick < 6) begin
      send_item(zrs_pkg::REQ_LOAD,
                zrs_pkg::IDX_W'($urandom_range(zrs_pkg::MAX_RANKS + 1, 2047)),
                zrs_pkg::VAL_W'($urandom), zrs_pkg::VAL_W'($urandom));
    end else if (pick < 16) begin
      // rewrite an entry between its neighbors so the table stays ordered
      k  = $urandom_range(1, zrs_pkg::MAX_RANKS);
      lo = sb.threshold(k - 1);
      hi = (k < n) ? sb.threshold(k + 1) : VAL_MAX;
      if (lo <= hi) u = zrs_pkg::VAL_W'($urandom_range(lo, hi));
      else u = zrs_pkg::VAL_W'($urandom);
      send_item(zrs_pkg::REQ_LOAD, k[zrs_pkg::IDX_W-1:0], u, zrs_pkg::VAL_W'($urandom));
    end else if (pick < 20) begin
      send_item(zrs_pkg::REQ_LOAD, zrs_pkg::IDX_W'($urandom_range(1, zrs_pkg::MAX_RANKS)),
                zrs_pkg::VAL_W'($urandom), zrs_pkg::VAL_W'($urandom));
    end else begin
      last = (n > 0) ? sb.threshold(n) : '0;
      k    = (n > 0) ? $urandom_range(1, n) : 1;
      case ($urandom_range(0, 9))
        0:       u = '0;
        1:       u = sb.threshold(k);
        2:       u = sb.threshold(k) + 1'b1;
        3:       u = VAL_MAX;
        4:       u = zrs_pkg::VAL_W'($urandom);
        default: u = zrs_pkg::VAL_W'($urandom_range(1, (last == 0) ? 1 : last));
      endcase
      send_item(zrs_pkg::REQ_SAMPLE, zrs_pkg::IDX_W'($urandom),
                zrs_pkg::VAL_W'($urandom), u);
    end
  endtask

  int phase_sizes [9] = '{5, 64, 1024, 2047, 0, 300, 17, 2, 1};

  initial begin
    int n;
    sb            = new();
    configs       = 0;
    idling        = 1'b1;
    hold_off_req  = 1'b0;
    in_valid      = 1'b0;
    req_type      = zrs_pkg::REQ_LOAD;
    entry_index   = '0;
    entry_value   = '0;
    uniform_value = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    rst           = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: single rank, out-of-range loads, zero and saturated values.
    write_rank_count(11'd1);
    send_item(zrs_pkg::REQ_LOAD, 11'd1, 31'd1000, '0);
    send_item(zrs_pkg::REQ_LOAD, 11'd0, VAL_MAX, VAL_MAX);
    send_item(zrs_pkg::REQ_LOAD, 11'd2047, VAL_MAX, VAL_MAX);
    send_item(zrs_pkg::REQ_LOAD, 11'd1025, 31'd5, '0);
    send_item(zrs_pkg::REQ_SAMPLE, '0, '0, 31'd0);
    send_item(zrs_pkg::REQ_SAMPLE, '1, VAL_MAX, 31'd1);
    send_item(zrs_pkg::REQ_SAMPLE, '0, '0, 31'd1000);
    send_item(zrs_pkg::REQ_SAMPLE, '0, '0, 31'd1001);
    send_item(zrs_pkg::REQ_SAMPLE, '0, '0, VAL_MAX);
    send_item(zrs_pkg::REQ_LOAD, 11'd1, 31'd0, '0);
    send_item(zrs_pkg::REQ_SAMPLE, '0, '0, 31'd0);
    send_item(zrs_pkg::REQ_SAMPLE, '0, '0, 31'd1);
    send_item(zrs_pkg::REQ_LOAD, 11'd1, VAL_MAX, '0);
    send_item(zrs_pkg::REQ_SAMPLE, '0, '0, VAL_MAX);
    halt_items();
    settle();
    write_rank_count(11'd0);
    send_item(zrs_pkg::REQ_SAMPLE, '0, '0, 31'd5);
    send_item(zrs_pkg::REQ_SAMPLE, '0, '0, VAL_MAX);
    // descending pair: search still lands on rank 1
    send_item(zrs_pkg::REQ_LOAD, 11'd1024, VAL_MAX, '0);
    send_item(zrs_pkg::REQ_LOAD, 11'd2, 31'd0, '0);
    halt_items();
    settle();
    write_rank_count(11'd2);
    send_item(zrs_pkg::REQ_SAMPLE, '0, '0, 31'd5);
    send_item(zrs_pkg::REQ_SAMPLE, '0, '0, VAL_MAX);
    halt_items();

    foreach (phase_sizes[p]) begin
      settle();
      write_rank_count(phase_sizes[p][zrs_pkg::IDX_W-1:0]);
      if (p >= 7) idling = 1'b0;
      else idling = ($urandom_range(0, 3) != 0);
      n = (phase_sizes[p] > zrs_pkg::MAX_RANKS) ? zrs_pkg::MAX_RANKS : phase_sizes[p];
      build_table(n);
      if (p == 2) hold_off_req = 1'b1;
      repeat (60) random_item(n);
      halt_items();
    end

    settle();
    if (sb.pending_ranks.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_ranks.size());
      sb.errors++;
    end
    $display("Covered %0d loads and %0d searches (%0d found, %0d not found)",
             sb.loads, sb.samples, sb.hits, sb.misses);
    $display("over %0d rank_count settings, including 0, 1, 1024 and 2047", configs);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
